// ===== sv/lhp_pkg.sv =====
// ----------------------------------------------------------------------------
// lhp_pkg
// Word types and field widths shared by the latency histogram core.
// ----------------------------------------------------------------------------
package lhp_pkg;

    localparam int RAW_W  = 40;
    localparam int LAT_W  = 39;
    localparam int FRAC_W = 25;
    localparam int PCT_W  = 10;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;
    localparam int Q_FRAC = 24;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [RAW_W-1:0]  sample_ns;
        logic [FRAC_W-1:0]        fraction;
    } t_in_word;

    typedef struct packed {
        logic [PCT_W-1:0] percentile_bucket;
        logic [LAT_W-1:0] minimum_ns;
        logic [LAT_W-1:0] maximum_ns;
        logic [CNT_W-1:0] sample_count;
        logic [SUM_W-1:0] latency_sum;
        logic [CNT_W-1:0] overflow_count;
    } t_out_word;

endpackage

// ===== sv/lhp_ram.sv =====
// ----------------------------------------------------------------------------
// lhp_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lhp_div.sv =====
// ----------------------------------------------------------------------------
// lhp_div
// Bucket index by reciprocal multiplication, quotient registered in the cycle
// after start.
// ----------------------------------------------------------------------------
module lhp_div #(
    parameter int NUM_BUCKETS   = 1000,
    parameter int NS_PER_BUCKET = 1000
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lhp_pkg::LAT_W-1:0]      i_dividend,
    output logic                           o_done,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_quot
);
    import lhp_pkg::*;

    localparam int QW = $clog2(NUM_BUCKETS);
    localparam longint unsigned LIMIT =
        longint'(NUM_BUCKETS) * longint'(NS_PER_BUCKET);
    localparam int DW = $clog2(LIMIT);
    localparam int KW = $clog2(NS_PER_BUCKET);
    localparam int SH = DW + KW;
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + longint'(NS_PER_BUCKET) - 64'd1) / longint'(NS_PER_BUCKET);
    localparam logic [MW-1:0] RECIP_W = MW'(RECIP);

    logic          r_done;
    logic [QW-1:0] r_quot;
    logic [PW-1:0] product;

    assign product = PW'(i_dividend[DW-1:0]) * PW'(RECIP_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= product[SH +: QW];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/latency_histogram_percentile_core.sv =====
// ----------------------------------------------------------------------------
// latency_histogram_percentile_core
// Latency histogram with min, max, count, sum and percentile query.
// A sample in range takes a bucket index by reciprocal multiply, then one
// read-modify-write of the bucket RAM; an overflow sample skips both.
// A query walks the buckets, one bucket RAM read per cycle.
// The result word may then wait on output stall before the next input is taken.
// After reset a clearing pass zeroes the bucket RAM, with input stalled until
// it ends.
// ----------------------------------------------------------------------------
module latency_histogram_percentile_core #(
    parameter int NUM_BUCKETS   = 1000,
    parameter int NS_PER_BUCKET = 1000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lhp_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lhp_pkg::t_out_word  o_out_word
);
    import lhp_pkg::*;

    localparam int AW = $clog2(NUM_BUCKETS);
    localparam int SW = CNT_W + AW;
    localparam int RW = FRAC_W + CNT_W - Q_FRAC;
    localparam int PW = FRAC_W + CNT_W;
    localparam logic [LAT_W-1:0] LIMIT =
        LAT_W'(longint'(NUM_BUCKETS) * longint'(NS_PER_BUCKET));
    localparam logic [AW-1:0] LAST = AW'(NUM_BUCKETS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_INC,
        S_WALK,
        S_DONE
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    t_state            r_state;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_didx;
    logic [AW-1:0]     r_idx;
    logic              r_pend;
    logic [SW-1:0]     r_seen;
    logic [RW-1:0]     r_rank;
    logic [PCT_W-1:0]  r_pct;
    logic [LAT_W-1:0]  r_min;
    logic [LAT_W-1:0]  r_max;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_ovf;
    logic              r_out_valid;
    t_out_word         r_out;

    logic              accept;
    logic [LAT_W-1:0]  lat;
    logic              lat_ovf;
    logic [SUM_W:0]    n_sum;
    logic [PW-1:0]     product;
    logic [SW-1:0]     n_seen;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [AW-1:0]     div_quot;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign lat       = i_in_word.sample_ns[RAW_W-1] ? '0 : i_in_word.sample_ns[LAT_W-1:0];
    assign lat_ovf   = (lat >= LIMIT);
    assign n_sum     = {1'b0, r_sum} + (SUM_W + 1)'(lat);
    assign product   = PW'(i_in_word.fraction) * PW'(r_count);
    assign n_seen    = r_seen + SW'(ram_rdata);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign div_start = accept && (i_in_word.op == OP_SAMPLE) && !lat_ovf;

    lhp_div #(
        .NUM_BUCKETS   (NUM_BUCKETS),
        .NS_PER_BUCKET (NS_PER_BUCKET)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (lat),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_raddr = r_addr;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_DIV: begin
                ram_raddr = div_quot;
            end
            S_INC: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = sat_inc(ram_rdata);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    lhp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_min       <= '1;
            r_max       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_ovf       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= (r_addr == LAST) ? '0 : r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_in_word.op == OP_SAMPLE) begin
                            r_pct <= '0;
                            if (lat < r_min) begin
                                r_min <= lat;
                            end
                            if (lat > r_max) begin
                                r_max <= lat;
                            end
                            r_count <= sat_inc(r_count);
                            r_sum   <= n_sum[SUM_W] ? '1 : n_sum[SUM_W-1:0];
                            if (lat_ovf) begin
                                r_ovf   <= sat_inc(r_ovf);
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_rank  <= product[PW-1:Q_FRAC];
                            r_addr  <= '0;
                            r_pend  <= 1'b0;
                            r_seen  <= '0;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_idx   <= div_quot;
                        r_state <= S_INC;
                    end
                end
                S_INC: begin
                    r_state <= S_DONE;
                end
                S_WALK: begin
                    r_addr <= (r_addr == LAST) ? r_addr : r_addr + 1'b1;
                    r_didx <= r_addr;
                    if (r_pend) begin
                        r_seen <= n_seen;
                    end
                    if (r_pend && (n_seen >= SW'(r_rank))) begin
                        r_pct   <= PCT_W'(r_didx);
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_pend && (r_didx == LAST)) begin
                        r_pct   <= PCT_W'(NUM_BUCKETS);
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_pend <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out.percentile_bucket <= r_pct;
            r_out.minimum_ns        <= r_min;
            r_out.maximum_ns        <= r_max;
            r_out.sample_count      <= r_count;
            r_out.latency_sum       <= r_sum;
            r_out.overflow_count    <= r_ovf;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("minimum above maximum after samples");

    a_empty_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_sum == '0) && (r_ovf == '0)))
        else $error("sum or overflow count without samples");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside sample path");

    a_accept_frees_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("result word not presented");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for latency_histogram_percentile_core. A local model of
// the bucket counters, extremes, count and sum predicts every result word;
// directed edge cases come first, then a long random mix of samples and
// percentile queries with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lhp_pkg::*;

    localparam int HIST_BUCKETS = 1000;
    localparam int BUCKET_NS    = 1000;
    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << Q_FRAC;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    logic [CNT_W-1:0] bucket_tally [HIST_BUCKETS];
    logic [CNT_W-1:0] overflow_tally;
    logic [CNT_W-1:0] samples_seen;
    logic [LAT_W-1:0] lat_floor;
    logic [LAT_W-1:0] lat_peak;
    logic [SUM_W-1:0] lat_total;

    t_out_word expected_words [$];
    int        error_count = 0;
    int        cycle_count = 0;
    logic      idle_on     = 1'b0;
    int        stall_left  = 0;

    latency_histogram_percentile_core #(
        .NUM_BUCKETS  (HIST_BUCKETS),
        .NS_PER_BUCKET(BUCKET_NS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic histogram_update(input t_in_word w);
        t_out_word        r;
        logic [LAT_W-1:0] lat;
        logic [63:0]      idx;
        logic [63:0]      rank;
        logic [63:0]      seen;
        int               hit;
        r = '0;
        if (w.op == OP_SAMPLE) begin
            lat = w.sample_ns[RAW_W-1] ? '0 : w.sample_ns[LAT_W-1:0];
            idx = 64'(lat) / BUCKET_NS;
            if (idx < HIST_BUCKETS) begin
                bucket_tally[idx] = sat_inc(bucket_tally[idx]);
            end else begin
                overflow_tally = sat_inc(overflow_tally);
            end
            if (lat < lat_floor) lat_floor = lat;
            if (lat > lat_peak) lat_peak = lat;
            samples_seen = sat_inc(samples_seen);
            if (lat_total > {SUM_W{1'b1}} - 64'(lat)) begin
                lat_total = {SUM_W{1'b1}};
            end else begin
                lat_total = lat_total + 64'(lat);
            end
        end else begin
            rank = (64'(w.fraction) * 64'(samples_seen)) >> Q_FRAC;
            seen = '0;
            hit  = HIST_BUCKETS;
            for (int i = 0; i < HIST_BUCKETS; i++) begin
                seen = seen + 64'(bucket_tally[i]);
                if (hit == HIST_BUCKETS && seen >= rank) hit = i;
            end
            r.percentile_bucket = PCT_W'(hit);
        end
        r.minimum_ns     = lat_floor;
        r.maximum_ns     = lat_peak;
        r.sample_count   = samples_seen;
        r.latency_sum    = lat_total;
        r.overflow_count = overflow_tally;
        expected_words.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected result word", 64'(got.sample_count), '0);
        end else begin
            want = expected_words.pop_front();
            compare_field("percentile_bucket", 64'(got.percentile_bucket),
                          64'(want.percentile_bucket));
            compare_field("minimum_ns", 64'(got.minimum_ns), 64'(want.minimum_ns));
            compare_field("maximum_ns", 64'(got.maximum_ns), 64'(want.maximum_ns));
            compare_field("sample_count", 64'(got.sample_count), 64'(want.sample_count));
            compare_field("latency_sum", got.latency_sum, want.latency_sum);
            compare_field("overflow_count", 64'(got.overflow_count),
                          64'(want.overflow_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_word(o_out_word);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 15);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_word(input t_in_word w);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        histogram_update(w);
    endtask

    function automatic t_in_word sample_word(input logic [RAW_W-1:0] lat);
        t_in_word w;
        w.op        = OP_SAMPLE;
        w.sample_ns = lat;
        w.fraction  = FRAC_W'($urandom());
        return w;
    endfunction

    function automatic t_in_word query_word(input logic [FRAC_W-1:0] frac);
        t_in_word w;
        w.op        = OP_QUERY;
        w.sample_ns = RAW_W'({$urandom(), $urandom()});
        w.fraction  = frac;
        return w;
    endfunction

    function automatic logic [RAW_W-1:0] pick_latency();
        logic [63:0] r64;
        int unsigned sel;
        r64 = {$urandom(), $urandom()};
        sel = $urandom_range(0, 99);
        if (sel < 30) return RAW_W'($urandom_range(0, 49_999));
        if (sel < 55) return RAW_W'($urandom_range(0, 999_999));
        if (sel < 70) begin
            return RAW_W'(64'($urandom_range(0, HIST_BUCKETS)) * BUCKET_NS
                          + 64'($urandom_range(0, 1)) * (BUCKET_NS - 1));
        end
        if (sel < 80) return {1'b1, r64[LAT_W-1:0]};
        if (sel < 90) return {1'b0, r64[LAT_W-1:0]};
        return r64[RAW_W-1:0];
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) return $urandom_range(0, 1) ? FRAC_ONE : '0;
        if (sel < 25) return FRAC_W'($urandom());
        if (sel < 40) return FRAC_W'($urandom_range(0, 65_535));
        return FRAC_W'($urandom_range(0, 1 << Q_FRAC));
    endfunction

    function automatic t_in_word random_word();
        if ($urandom_range(0, 99) < 9) return query_word(pick_fraction());
        return sample_word(pick_latency());
    endfunction

    task automatic test_empty_histogram();
        idle_on <= 1'b1;
        send_word(query_word('0));
        send_word(query_word(FRAC_ONE));
        send_word(query_word('1));
    endtask

    task automatic test_sample_extremes();
        send_word(sample_word('0));
        send_word(sample_word({1'b1, {LAT_W{1'b0}}}));
        send_word(sample_word('1));
        send_word(sample_word(RAW_W'(BUCKET_NS - 1)));
        send_word(sample_word(RAW_W'(BUCKET_NS)));
        send_word(sample_word(RAW_W'(HIST_BUCKETS * BUCKET_NS - 1)));
        send_word(sample_word(RAW_W'(HIST_BUCKETS * BUCKET_NS)));
        send_word(sample_word({1'b0, {LAT_W{1'b1}}}));
    endtask

    task automatic test_percentile_edges();
        send_word(query_word('0));
        send_word(query_word(FRAC_W'(1)));
        send_word(query_word(FRAC_ONE >> 1));
        send_word(query_word(FRAC_ONE));
        send_word(query_word(FRAC_ONE + 1'b1));
        send_word(query_word('1));
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 1300; n++) begin
            if (n % 50 == 0) idle_on <= ($urandom_range(0, 3) != 0);
            send_word(random_word());
        end
    endtask

    task automatic test_streaming();
        idle_on <= 1'b0;
        repeat (50) send_word(random_word());
    endtask

    initial begin
        foreach (bucket_tally[i]) bucket_tally[i] = '0;
        overflow_tally = '0;
        samples_seen   = '0;
        lat_floor      = '1;
        lat_peak       = '0;
        lat_total      = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_histogram();
        test_sample_extremes();
        test_percentile_edges();
        test_random_mix();
        test_streaming();

        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (HIST_BUCKETS + 16) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
